>>> design/sfla_pkg.sv
package sfla_pkg;

    // Request codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_NO_FIT     = 2'd1;
    localparam logic [1:0] STATUS_TABLE_FULL = 2'd2;

    // Configuration register indexes
    localparam logic CFG_FIT_POLICY  = 1'b0;
    localparam logic CFG_MEMORY_SIZE = 1'b1;

    // Fit policies
    localparam logic FIT_FIRST = 1'b0;
    localparam logic FIT_BEST  = 1'b1;

    // Hole table access control
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic set_valid;
        logic clr_en;
        logic reload;
        logic reload_valid;
    } tbl_ctl_t;

    // Candidates found by a table scan
    typedef struct packed {
        logic pick_found;
        logic before_found;
        logic after_found;
        logic slot_found;
    } scan_flags_t;

endpackage

>>> design/sfla_table.sv
module sfla_table #(
    parameter int ENTRIES = 32,
    parameter int AW = 16,
    parameter logic [AW:0] INIT_LEN = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sfla_pkg::tbl_ctl_t         ctl,
    input  logic [$clog2(ENTRIES)-1:0] rd_addr,
    input  logic [$clog2(ENTRIES)-1:0] wr_addr,
    input  logic [AW-1:0]              wr_start,
    input  logic [AW:0]                wr_len,
    input  logic [$clog2(ENTRIES)-1:0] clr_addr,
    output logic [AW-1:0]              rd_start,
    output logic [AW:0]                rd_len,
    output logic                       rd_valid
);

    localparam int IW = $clog2(ENTRIES);
    localparam int LW = AW + 1;

    logic [AW+LW-1:0] table_mem [ENTRIES];
    logic [AW+LW-1:0] rd_word_reg;

    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    // entry zero holds the reset hole until its first write
    logic               init0_reg;
    logic               rd_init_reg;
    logic               rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            table_mem[wr_addr] <= {wr_start, wr_len};
        end
        if (ctl.rd_en)
        begin
            rd_word_reg <= table_mem[rd_addr];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.reload)
        begin
            valid_next    = '0;
            valid_next[0] = ctl.reload_valid;
        end
        else
        begin
            if (ctl.clr_en)
            begin
                valid_next[clr_addr] = 1'b0;
            end
            if (ctl.wr_en && ctl.set_valid)
            begin
                valid_next[wr_addr] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= ENTRIES'(1);
            init0_reg    <= 1'b1;
            rd_init_reg  <= 1'b0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (ctl.wr_en && wr_addr == IW'(0))
            begin
                init0_reg <= 1'b0;
            end
            if (ctl.rd_en)
            begin
                rd_init_reg  <= init0_reg && rd_addr == IW'(0);
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_start = rd_init_reg ? '0 : rd_word_reg[AW+LW-1:LW];
    assign rd_len   = rd_init_reg ? INIT_LEN : rd_word_reg[LW-1:0];
    assign rd_valid = rd_valid_reg;

endmodule

>>> design/sfla_scan.sv
module sfla_scan #(
    parameter int ENTRIES = 32,
    parameter int AW = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       clear,
    input  logic                       cmp_en,
    input  logic [$clog2(ENTRIES)-1:0] cmp_idx,
    input  logic [AW-1:0]              e_start,
    input  logic [AW:0]                e_len,
    input  logic                       e_valid,
    input  logic                       command,
    input  logic                       fit_policy,
    input  logic [AW-1:0]              req_start,
    input  logic [AW:0]                req_size,
    output sfla_pkg::scan_flags_t      flags,
    output logic [$clog2(ENTRIES)-1:0] pick_idx,
    output logic [AW-1:0]              pick_start,
    output logic [AW:0]                pick_len,
    output logic [$clog2(ENTRIES)-1:0] before_idx,
    output logic [AW-1:0]              before_start,
    output logic [AW:0]                before_len,
    output logic [$clog2(ENTRIES)-1:0] after_idx,
    output logic [AW:0]                after_len,
    output logic [$clog2(ENTRIES)-1:0] slot_idx
);

    localparam int IW = $clog2(ENTRIES);
    localparam int EW = AW + 2;

    sfla_pkg::scan_flags_t flags_reg;
    sfla_pkg::scan_flags_t flags_next;
    logic [IW-1:0] pick_idx_reg;
    logic [AW-1:0] pick_start_reg;
    logic [AW:0]   pick_len_reg;
    logic [IW-1:0] before_idx_reg;
    logic [AW-1:0] before_start_reg;
    logic [AW:0]   before_len_reg;
    logic [IW-1:0] after_idx_reg;
    logic [AW:0]   after_len_reg;
    logic [IW-1:0] slot_idx_reg;

    logic          fits;
    logic          better;
    logic          take_pick;
    logic          take_before;
    logic          take_after;
    logic          take_slot;
    logic [EW-1:0] hole_end;
    logic [EW-1:0] req_end;

    always_comb
    begin
        hole_end = EW'(e_start) + EW'(e_len);
        req_end  = EW'(req_start) + EW'(req_size);
        fits     = e_valid && e_len >= req_size;
        if (!flags_reg.pick_found)
        begin
            better = 1'b1;
        end
        else if (fit_policy == sfla_pkg::FIT_FIRST)
        begin
            better = e_start < pick_start_reg;
        end
        else
        begin
            better = e_len < pick_len_reg ||
                     (e_len == pick_len_reg && e_start < pick_start_reg);
        end

        take_pick   = cmp_en && command == sfla_pkg::CMD_ALLOC && fits && better;
        take_slot   = cmp_en && command == sfla_pkg::CMD_FREE && !e_valid &&
                      !flags_reg.slot_found;
        take_before = cmp_en && command == sfla_pkg::CMD_FREE && e_valid &&
                      !flags_reg.before_found && hole_end == EW'(req_start);
        take_after  = cmp_en && command == sfla_pkg::CMD_FREE && e_valid &&
                      !flags_reg.after_found && EW'(e_start) == req_end;

        flags_next = flags_reg;
        if (clear)
        begin
            flags_next = '0;
        end
        else
        begin
            if (take_pick)
            begin
                flags_next.pick_found = 1'b1;
            end
            if (take_before)
            begin
                flags_next.before_found = 1'b1;
            end
            if (take_after)
            begin
                flags_next.after_found = 1'b1;
            end
            if (take_slot)
            begin
                flags_next.slot_found = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_pick)
        begin
            pick_idx_reg   <= cmp_idx;
            pick_start_reg <= e_start;
            pick_len_reg   <= e_len;
        end
        if (take_before)
        begin
            before_idx_reg   <= cmp_idx;
            before_start_reg <= e_start;
            before_len_reg   <= e_len;
        end
        if (take_after)
        begin
            after_idx_reg <= cmp_idx;
            after_len_reg <= e_len;
        end
        if (take_slot)
        begin
            slot_idx_reg <= cmp_idx;
        end
    end

    assign flags        = flags_reg;
    assign pick_idx     = pick_idx_reg;
    assign pick_start   = pick_start_reg;
    assign pick_len     = pick_len_reg;
    assign before_idx   = before_idx_reg;
    assign before_start = before_start_reg;
    assign before_len   = before_len_reg;
    assign after_idx    = after_idx_reg;
    assign after_len    = after_len_reg;
    assign slot_idx     = slot_idx_reg;

endmodule

>>> design/segment_free_list_allocator.sv
// Free-hole allocator. Each request (allocate or free) is taken one at a time
// and answered with exactly one result beat. A taken request walks the whole
// hole table through its single read port, one entry per cycle, then writes
// the table back in ST_UPDATE and hands the result to the output register in
// ST_RESP. The hand-over in ST_RESP waits while the previous result is still
// stalled at the output. A new request is taken while the last result waits
// to be taken.
// Writing memory_size reloads the table as one hole in the same cycle (an
// empty table if the size is zero); the write is dropped in ST_UPDATE. No
// clearing pass is needed after reset.
module segment_free_list_allocator #(
    parameter int FREE_ENTRIES = 32,
    parameter int ADDR_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic                 cfg_index,
    input  logic [ADDR_BITS:0]   cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 command,
    input  logic [ADDR_BITS-1:0] block_start,
    input  logic [ADDR_BITS:0]   block_size,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           status,
    output logic [ADDR_BITS-1:0] granted_start
);

    localparam int AW = ADDR_BITS;
    localparam int LW = AW + 1;
    localparam int SW = AW + 3;
    localparam int IW = $clog2(FREE_ENTRIES);
    localparam longint unsigned MEM_MAX_L = 64'd1 << AW;
    localparam logic [LW-1:0] MEM_MAX = LW'(MEM_MAX_L);
    localparam logic [LW-1:0] RESET_LEN = LW'((MEM_MAX_L < 64'd4096) ? MEM_MAX_L : 64'd4096);
    localparam logic [LW-1:0] LEN_MAX = '1;
    localparam logic [IW-1:0] LAST_IDX = IW'(FREE_ENTRIES - 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_RESP   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic          fit_policy_reg;
    logic          cmd_reg;
    logic [AW-1:0] req_start_reg;
    logic [LW-1:0] req_size_reg;

    logic [IW-1:0] rd_idx_reg;
    logic          rd_active_reg;
    logic [IW-1:0] cmp_idx_reg;
    logic          cmp_vld_reg;

    logic [1:0]    res_status_reg;
    logic [1:0]    res_status_next;
    logic [AW-1:0] res_granted_reg;
    logic [AW-1:0] res_granted_next;

    logic          out_valid_reg;
    logic [1:0]    status_reg;
    logic [AW-1:0] granted_reg;

    logic          accept;
    logic          out_free;

    sfla_pkg::tbl_ctl_t    ctl;
    sfla_pkg::scan_flags_t flags;
    logic [IW-1:0] wr_addr;
    logic [AW-1:0] wr_start;
    logic [LW-1:0] wr_len;
    logic [IW-1:0] clr_addr;
    logic [AW-1:0] e_start;
    logic [LW-1:0] e_len;
    logic          e_valid;

    logic [IW-1:0] pick_idx;
    logic [AW-1:0] pick_start;
    logic [LW-1:0] pick_len;
    logic [IW-1:0] before_idx;
    logic [AW-1:0] before_start;
    logic [LW-1:0] before_len;
    logic [IW-1:0] after_idx;
    logic [LW-1:0] after_len;
    logic [IW-1:0] slot_idx;

    logic [LW-1:0] cfg_size;
    logic [LW-1:0] alloc_len;
    logic [AW-1:0] alloc_start;
    logic [SW-1:0] merge_sum;
    logic [LW-1:0] merge_len;

    assign accept   = in_valid && !in_stall;
    assign in_stall = state_reg != ST_IDLE;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cmp_vld_reg && cmp_idx_reg == LAST_IDX)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fit_policy_reg <= sfla_pkg::FIT_FIRST;
            rd_active_reg  <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write_en && cfg_index == sfla_pkg::CFG_FIT_POLICY)
            begin
                fit_policy_reg <= cfg_data[0];
            end
            if (accept)
            begin
                rd_active_reg <= 1'b1;
            end
            else if (rd_active_reg && rd_idx_reg == LAST_IDX)
            begin
                rd_active_reg <= 1'b0;
            end
            cmp_vld_reg <= rd_active_reg;
            if (state_reg == ST_RESP && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg       <= command;
            req_start_reg <= block_start;
            req_size_reg  <= block_size;
            rd_idx_reg    <= '0;
        end
        else if (rd_active_reg)
        begin
            rd_idx_reg <= rd_idx_reg + IW'(1);
        end
        cmp_idx_reg <= rd_idx_reg;
        if (state_reg == ST_UPDATE)
        begin
            res_status_reg  <= res_status_next;
            res_granted_reg <= res_granted_next;
        end
        if (state_reg == ST_RESP && out_free)
        begin
            status_reg  <= res_status_reg;
            granted_reg <= res_granted_reg;
        end
    end

    // Table write-back and memory_size reload. The state machine keeps write-back
    // apart from scans; a reload write is not held off while a scan runs.
    always_comb
    begin
        cfg_size    = (cfg_data > MEM_MAX) ? MEM_MAX : cfg_data;
        alloc_len   = pick_len - req_size_reg;
        alloc_start = pick_start + req_size_reg[AW-1:0];
        merge_sum   = SW'(flags.before_found ? before_len : after_len) + SW'(req_size_reg) +
                      SW'((flags.before_found && flags.after_found) ? after_len : '0);
        merge_len   = (merge_sum > SW'(LEN_MAX)) ? LEN_MAX : merge_sum[LW-1:0];

        ctl              = '0;
        ctl.rd_en        = rd_active_reg;
        wr_addr          = '0;
        wr_start         = '0;
        wr_len           = '0;
        clr_addr         = '0;
        res_status_next  = sfla_pkg::STATUS_OK;
        res_granted_next = '0;

        if (state_reg == ST_UPDATE)
        begin
            if (cmd_reg == sfla_pkg::CMD_ALLOC)
            begin
                if (req_size_reg == '0 || !flags.pick_found)
                begin
                    res_status_next = sfla_pkg::STATUS_NO_FIT;
                end
                else
                begin
                    res_granted_next = pick_start;
                    if (alloc_len == '0)
                    begin
                        ctl.clr_en = 1'b1;
                        clr_addr   = pick_idx;
                    end
                    else
                    begin
                        ctl.wr_en = 1'b1;
                        wr_addr   = pick_idx;
                        wr_start  = alloc_start;
                        wr_len    = alloc_len;
                    end
                end
            end
            else if (req_size_reg != '0)
            begin
                priority if (flags.before_found)
                begin
                    ctl.wr_en  = 1'b1;
                    wr_addr    = before_idx;
                    wr_start   = before_start;
                    wr_len     = merge_len;
                    ctl.clr_en = flags.after_found;
                    clr_addr   = after_idx;
                end
                else if (flags.after_found)
                begin
                    ctl.wr_en = 1'b1;
                    wr_addr   = after_idx;
                    wr_start  = req_start_reg;
                    wr_len    = merge_len;
                end
                else if (flags.slot_found)
                begin
                    ctl.wr_en     = 1'b1;
                    ctl.set_valid = 1'b1;
                    wr_addr       = slot_idx;
                    wr_start      = req_start_reg;
                    wr_len        = req_size_reg;
                end
                else
                begin
                    res_status_next = sfla_pkg::STATUS_TABLE_FULL;
                end
            end
        end
        else if (cfg_write_en && cfg_index == sfla_pkg::CFG_MEMORY_SIZE)
        begin
            // reload as one hole covering the configured memory size, clamped to the address space
            ctl.reload       = 1'b1;
            ctl.reload_valid = cfg_size != '0;
            ctl.wr_en        = 1'b1;
            wr_addr          = '0;
            wr_start         = '0;
            wr_len           = cfg_size;
        end
    end

    sfla_table #(
        .ENTRIES  (FREE_ENTRIES),
        .AW       (AW),
        .INIT_LEN (RESET_LEN)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .rd_addr  (rd_idx_reg),
        .wr_addr  (wr_addr),
        .wr_start (wr_start),
        .wr_len   (wr_len),
        .clr_addr (clr_addr),
        .rd_start (e_start),
        .rd_len   (e_len),
        .rd_valid (e_valid)
    );

    sfla_scan #(
        .ENTRIES (FREE_ENTRIES),
        .AW      (AW)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .clear        (accept),
        .cmp_en       (cmp_vld_reg),
        .cmp_idx      (cmp_idx_reg),
        .e_start      (e_start),
        .e_len        (e_len),
        .e_valid      (e_valid),
        .command      (cmd_reg),
        .fit_policy   (fit_policy_reg),
        .req_start    (req_start_reg),
        .req_size     (req_size_reg),
        .flags        (flags),
        .pick_idx     (pick_idx),
        .pick_start   (pick_start),
        .pick_len     (pick_len),
        .before_idx   (before_idx),
        .before_start (before_start),
        .before_len   (before_len),
        .after_idx    (after_idx),
        .after_len    (after_len),
        .slot_idx     (slot_idx)
    );

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign granted_start = granted_reg;

endmodule

>>> design/sfla_checker.sv
module sfla_checker #(
    parameter int ADDR_BITS = 16
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [1:0]           status,
    input logic [ADDR_BITS-1:0] granted_start
);

    // a taken request keeps the input side busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a request is in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(granted_start))
        else $error("stalled result beat changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == sfla_pkg::STATUS_OK || status == sfla_pkg::STATUS_NO_FIT ||
                      status == sfla_pkg::STATUS_TABLE_FULL)
        else $error("undefined status code");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != sfla_pkg::STATUS_OK |-> granted_start == '0)
        else $error("failed request carries a start offset");

    // a fresh result beat only follows a cycle of request work
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result beat without a request in flight");

endmodule

bind segment_free_list_allocator sfla_checker #(
    .ADDR_BITS (ADDR_BITS)
) u_sfla_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .granted_start (granted_start)
);

>>> verif/tb_segment_free_list_allocator.sv
module tb_segment_free_list_allocator;

    localparam int HOLE_SLOTS = 32;
    localparam logic [16:0] SIZE_ALL_ONES = 17'h1FFFF;
    localparam logic [16:0] ADDR_SPAN = 17'h10000;

    typedef struct {
        logic        cmd;
        logic [15:0] start;
        logic [16:0] size;
    } request_t;

    typedef struct {
        logic        cmd;
        logic [16:0] size;
        logic [1:0]  code;
        logic [15:0] grant;
    } outcome_t;

    typedef struct {
        logic [15:0] start;
        logic [16:0] size;
    } span_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_write_en = 1'b0;
    logic        cfg_index = sfla_pkg::CFG_FIT_POLICY;
    logic [16:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        command = sfla_pkg::CMD_ALLOC;
    logic [15:0] block_start = '0;
    logic [16:0] block_size = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [15:0] granted_start;

    request_t pending_reqs[$];
    outcome_t awaited[$];
    span_t    live_blocks[$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    int mismatches = 0;

    // Shadow copy of the hole table and the two registers
    logic        fit_mode;
    logic [16:0] mem_bytes;
    logic [15:0] hole_base [HOLE_SLOTS];
    logic [16:0] hole_len [HOLE_SLOTS];
    logic        hole_used [HOLE_SLOTS];

    segment_free_list_allocator #(
        .FREE_ENTRIES(HOLE_SLOTS),
        .ADDR_BITS(16)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .block_start(block_start),
        .block_size(block_size),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .granted_start(granted_start)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void reload_holes();
        for (int i = 0; i < HOLE_SLOTS; i++)
        begin
            hole_base[i] = '0;
            hole_len[i] = '0;
            hole_used[i] = 1'b0;
        end
        if (mem_bytes != 0)
        begin
            hole_len[0] = mem_bytes;
            hole_used[0] = 1'b1;
        end
    endfunction

    function automatic logic [16:0] sat_len(input logic [16:0] a, input logic [16:0] b);
        logic [17:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[17] ? SIZE_ALL_ONES : sum[16:0];
    endfunction

    // Expected answer to one request; updates the shadow table
    function automatic void serve_request(input logic cmd, input logic [15:0] start,
                                          input logic [16:0] size,
                                          output logic [1:0] code, output logic [15:0] grant);
        int pick;
        int below;
        int above;
        int slot;
        int end_addr;
        pick = -1;
        below = -1;
        above = -1;
        slot = -1;
        grant = '0;
        if (cmd == sfla_pkg::CMD_ALLOC)
        begin
            code = sfla_pkg::STATUS_NO_FIT;
            if (size != 0)
            begin
                for (int i = 0; i < HOLE_SLOTS; i++)
                begin
                    if (hole_used[i] && hole_len[i] >= size)
                    begin
                        if (pick < 0)
                            pick = i;
                        else if (fit_mode == sfla_pkg::FIT_FIRST)
                        begin
                            if (hole_base[i] < hole_base[pick])
                                pick = i;
                        end
                        else if (hole_len[i] < hole_len[pick] ||
                                 (hole_len[i] == hole_len[pick] &&
                                  hole_base[i] < hole_base[pick]))
                            pick = i;
                    end
                end
            end
            if (pick >= 0)
            begin
                code = sfla_pkg::STATUS_OK;
                grant = hole_base[pick];
                hole_base[pick] = hole_base[pick] + size[15:0];
                hole_len[pick] = hole_len[pick] - size;
                if (hole_len[pick] == 0)
                begin
                    hole_used[pick] = 1'b0;
                    hole_base[pick] = '0;
                end
            end
        end
        else
        begin
            code = sfla_pkg::STATUS_OK;
            end_addr = int'(start) + int'(size);
            if (size != 0)
            begin
                for (int i = 0; i < HOLE_SLOTS; i++)
                begin
                    if (!hole_used[i])
                    begin
                        if (slot < 0)
                            slot = i;
                    end
                    else
                    begin
                        if (below < 0 && int'(hole_base[i]) + int'(hole_len[i]) == int'(start))
                            below = i;
                        if (above < 0 && int'(hole_base[i]) == end_addr)
                            above = i;
                    end
                end
                if (below >= 0)
                begin
                    hole_len[below] = sat_len(hole_len[below], size);
                    if (above >= 0)
                    begin
                        hole_len[below] = sat_len(hole_len[below], hole_len[above]);
                        hole_used[above] = 1'b0;
                        hole_base[above] = '0;
                        hole_len[above] = '0;
                    end
                end
                else if (above >= 0)
                begin
                    hole_base[above] = start;
                    hole_len[above] = sat_len(hole_len[above], size);
                end
                else if (slot < 0)
                    code = sfla_pkg::STATUS_TABLE_FULL;
                else
                begin
                    hole_base[slot] = start;
                    hole_len[slot] = size;
                    hole_used[slot] = 1'b1;
                end
            end
        end
    endfunction

    function automatic void flag(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    // Request driver: hold a stalled beat, otherwise load the next one or idle
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        request_t next_req;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!(in_valid && in_stall))
        begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_req = pending_reqs.pop_front();
                in_valid    <= 1'b1;
                command     <= next_req.cmd;
                block_start <= next_req.start;
                block_size  <= next_req.size;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Result checker and request predictor
    always @(posedge clk)
    begin : watch_beats
        outcome_t head;
        logic [1:0] code;
        logic [15:0] grant;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited.size() == 0)
                    flag($sformatf("result with nothing outstanding: status=%0d start=%0d",
                                   status, granted_start));
                else
                begin
                    head = awaited.pop_front();
                    if (status !== head.code || granted_start !== head.grant)
                        flag($sformatf("status exp %0d got %0d, start exp %0d got %0d",
                                       head.code, status, head.grant, granted_start));
                    else if (head.cmd == sfla_pkg::CMD_ALLOC &&
                             head.code == sfla_pkg::STATUS_OK)
                        live_blocks.push_back('{start: head.grant, size: head.size});
                end
            end
            if (in_valid && !in_stall)
            begin
                serve_request(command, block_start, block_size, code, grant);
                awaited.push_back('{cmd: command, size: block_size, code: code, grant: grant});
            end
        end
    end

    task automatic queue_req(input logic cmd, input logic [15:0] start, input logic [16:0] size);
        pending_reqs.push_back('{cmd: cmd, start: start, size: size});
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || in_valid || awaited.size() != 0);
    endtask

    task automatic write_reg(input logic idx, input logic [16:0] val);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        if (idx == sfla_pkg::CFG_FIT_POLICY)
            fit_mode = val[0];
        else
        begin
            mem_bytes = (val > ADDR_SPAN) ? ADDR_SPAN : val;
            reload_holes();
            live_blocks.delete();
        end
    endtask

    // One random phase: mostly allocations and frees of blocks that were
    // really granted; scatter mode also drops small frees at random places
    task automatic run_phase(input logic fit, input logic [16:0] mem, input int idle_in,
                             input int idle_out, input int n, input bit scatter);
        int span;
        int roll;
        int pick;
        span_t blk;
        drain();
        write_reg(sfla_pkg::CFG_FIT_POLICY, 17'(fit));
        write_reg(sfla_pkg::CFG_MEMORY_SIZE, mem);
        send_idle_pct = idle_in;
        stall_pct = idle_out;
        for (int k = 0; k < n; k++)
        begin
            while (pending_reqs.size() >= 2)
                @(negedge clk);
            // hold off until the block has answered everything
            if (k == n / 2)
                drain();
            span = (mem_bytes == 0) ? 64 : int'(mem_bytes);
            roll = $urandom_range(99);
            if (roll < 8)
                queue_req(logic'($urandom_range(1)), 16'($urandom),
                          17'($urandom_range(0, 131071)));
            else if (scatter && roll < 45)
                queue_req(sfla_pkg::CMD_FREE, 16'($urandom), 17'($urandom_range(1, 64)));
            else if (roll < 50 && live_blocks.size() != 0)
            begin
                pick = $urandom_range(live_blocks.size() - 1);
                blk = live_blocks[pick];
                live_blocks.delete(pick);
                queue_req(sfla_pkg::CMD_FREE, blk.start, blk.size);
            end
            else if (roll < 56)
                queue_req(sfla_pkg::CMD_ALLOC, 16'($urandom), 17'($urandom_range(1, span + 1)));
            else
                queue_req(sfla_pkg::CMD_ALLOC, 16'($urandom),
                          17'($urandom_range(1, (span + 7) / 8)));
        end
        drain();
    endtask

    initial
    begin
        fit_mode = sfla_pkg::FIT_FIRST;
        mem_bytes = 17'd4096;
        reload_holes();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // First fit on the reset table
        queue_req(sfla_pkg::CMD_ALLOC, 16'd0, 17'd0);
        queue_req(sfla_pkg::CMD_FREE, 16'd5, 17'd0);
        queue_req(sfla_pkg::CMD_ALLOC, 16'hFFFF, 17'd4097);
        queue_req(sfla_pkg::CMD_ALLOC, 16'd0, 17'd100);
        queue_req(sfla_pkg::CMD_ALLOC, 16'd0, 17'd200);
        queue_req(sfla_pkg::CMD_ALLOC, 16'd0, 17'd300);
        queue_req(sfla_pkg::CMD_FREE, 16'd0, 17'd100);
        queue_req(sfla_pkg::CMD_FREE, 16'd300, 17'd300);
        queue_req(sfla_pkg::CMD_FREE, 16'd100, 17'd200);
        queue_req(sfla_pkg::CMD_ALLOC, 16'd0, 17'd4096);
        queue_req(sfla_pkg::CMD_ALLOC, 16'd0, 17'd1);
        // carve across the top of the address space so the start wraps
        queue_req(sfla_pkg::CMD_FREE, 16'hFFFF, 17'd2);
        queue_req(sfla_pkg::CMD_ALLOC, 16'd0, 17'd1);
        queue_req(sfla_pkg::CMD_ALLOC, 16'd0, 17'd1);
        // merge into a full-length hole so the length saturates
        queue_req(sfla_pkg::CMD_FREE, 16'd1, SIZE_ALL_ONES);
        queue_req(sfla_pkg::CMD_FREE, 16'd0, 17'd1);
        queue_req(sfla_pkg::CMD_FREE, 16'd0, ADDR_SPAN);
        drain();

        // Best fit: equal lengths, equal starts, duplicate neighbors
        write_reg(sfla_pkg::CFG_FIT_POLICY, 17'(sfla_pkg::FIT_BEST));
        write_reg(sfla_pkg::CFG_MEMORY_SIZE, 17'd0);
        queue_req(sfla_pkg::CMD_FREE, 16'd100, 17'd10);
        queue_req(sfla_pkg::CMD_FREE, 16'd200, 17'd10);
        queue_req(sfla_pkg::CMD_FREE, 16'd30, 17'd20);
        queue_req(sfla_pkg::CMD_ALLOC, 16'd0, 17'd10);
        queue_req(sfla_pkg::CMD_FREE, 16'd400, 17'd5);
        queue_req(sfla_pkg::CMD_FREE, 16'd400, 17'd5);
        queue_req(sfla_pkg::CMD_ALLOC, 16'd0, 17'd5);
        queue_req(sfla_pkg::CMD_FREE, 16'd400, 17'd5);
        queue_req(sfla_pkg::CMD_FREE, 16'd405, 17'd1);

        run_phase(sfla_pkg::FIT_FIRST, 17'd4096, 0, 0, 250, 1'b0);
        run_phase(sfla_pkg::FIT_BEST, ADDR_SPAN, 58, 0, 250, 1'b0);
        run_phase(sfla_pkg::FIT_FIRST, 17'd1, 0, 58, 80, 1'b0);
        run_phase(sfla_pkg::FIT_BEST, SIZE_ALL_ONES, 28, 28, 220, 1'b0);
        run_phase(sfla_pkg::FIT_FIRST, 17'd0, 28, 28, 250, 1'b1);
        run_phase(logic'($urandom_range(1)), 17'($urandom_range(1, 65536)), 0, 0, 180, 1'b0);
        run_phase(sfla_pkg::FIT_BEST, 17'd0, 0, 58, 150, 1'b1);

        repeat (50) @(posedge clk);
        if (mismatches == 0 && awaited.size() == 0)
            $display("PASS segment_free_list_allocator");
        else
            $display("FAIL segment_free_list_allocator");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL segment_free_list_allocator");
        $finish;
    end

endmodule

>>> files.f
design/sfla_pkg.sv
design/sfla_table.sv
design/sfla_scan.sv
design/segment_free_list_allocator.sv
design/sfla_checker.sv
verif/tb_segment_free_list_allocator.sv
